[sv/phib_pkg.sv]
// Package for the pose history buffer: item types, stored entry type, codes and sizes.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package phib_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 65;
  localparam int DEN_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RETENTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP   = 2'd1;

  localparam logic [31:0] RETENTION_RST = 32'd2000;
  localparam logic [31:0] MAX_GAP_RST   = 32'd200;
  localparam logic [31:0] MS_PER_S      = 32'd1000;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_POSE   = 2'd1;
  localparam logic [1:0] OP_YAW    = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [3:0] ST_APPENDED = 4'd0;
  localparam logic [3:0] ST_EPOCH    = 4'd1;
  localparam logic [3:0] ST_REVISED  = 4'd2;
  localparam logic [3:0] ST_OOO      = 4'd3;
  localparam logic [3:0] ST_UNSET    = 4'd4;
  localparam logic [3:0] ST_OK       = 4'd5;
  localparam logic [3:0] ST_EMPTY    = 4'd6;
  localparam logic [3:0] ST_EXPIRED  = 4'd7;
  localparam logic [3:0] ST_PENDING  = 4'd8;
  localparam logic [3:0] ST_GAP      = 4'd9;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               host_clock;
    logic [31:0]        time_ms;
    logic [31:0]        epoch;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [31:0]        cur_epoch;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [15:0] out_heading;
    logic signed [31:0] yaw_rate;
    logic               exact;
  } out_item_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
  } entry_t;

endpackage
`default_nettype wire

[sv/phib_div.sv]
// Restoring divider, one quotient bit per cycle, for the pose history buffer.
// Depends on phib_pkg for its default widths.
`timescale 1ns / 1ps
`default_nettype none
module phib_div #(
  parameter int NW = phib_pkg::PROD_W,
  parameter int DW = phib_pkg::DEN_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo;
  logic [DW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      rem_sh;
  logic             ge;
  logic [DW:0]      rem_next;

  always_comb begin
    rem_sh   = {rem, quo[NW-1]};
    ge       = rem_sh >= {1'b0, divisor};
    rem_next = ge ? rem_sh - {1'b0, divisor} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        cnt  <= CNT_W'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[NW-2:0], ge};
        rem <= rem_next[DW-1:0];
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

[sv/pose_history_interp_buffer.sv]
// Top level of the pose history buffer: entry memory, sequencer and result register.
// Depends on phib_pkg and phib_div.
//
//   channel | signals                         | moves
//   in      | in_valid in_ready in_item       | one request item
//   out     | out_valid out_ready out_item    | one result item per request
//   cfg     | cfg_valid cfg_ready cfg_index   | one register write, always taken
//           | cfg_data                        |
//
// Each item runs alone through the sequencer; every memory read is registered and its data
// is used in the state after the one that sets the address. A new in-order append writes
// its entry, then drops expired entries one at a time; a pose lookup reads both ends, runs a
// binary search, reads the two neighbours and makes up to three division passes; a yaw lookup makes one.
// Reset clears pointers, count and epoch; entries are valid only within the count.
// A waiting result holds the next item in the last sequencer step only.
`timescale 1ns / 1ps
`default_nettype none
module pose_history_interp_buffer #(
  parameter int DEPTH = phib_pkg::DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire phib_pkg::in_item_t             in_item,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output phib_pkg::out_item_t                 out_item,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [phib_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_APP_RD, S_APP_CHK, S_APP_WR, S_EXP_RD, S_EXP_CHK,
    S_LK_RD0, S_LK_RD1, S_LK_CHK, S_BS_RD, S_BS_CHK, S_PICK,
    S_RD_B, S_RD_A, S_EVAL, S_LSET, S_MUL, S_DIV_WAIT, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_X, PH_Y, PH_H, PH_YAW} phase_t;

  state_t              state;
  phase_t              phase;
  phib_pkg::in_item_t  in_r;
  phib_pkg::out_item_t res;
  phib_pkg::entry_t    mem [DEPTH];
  phib_pkg::entry_t    rdata;
  phib_pkg::entry_t    wdata;
  phib_pkg::entry_t    ea;
  phib_pkg::entry_t    eb;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic                we;
  logic [AW-1:0]       oldest;
  logic [AW-1:0]       oldest_inc;
  logic [CW-1:0]       count;
  logic [31:0]         cur_epoch;
  logic                have_epoch;
  logic [31:0]         retention;
  logic [31:0]         max_gap;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       hi;
  logic [CW-1:0]       mid;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       pick;
  logic [CW-1:0]       idx_prev;
  logic                full;
  logic [31:0]         num;
  logic [31:0]         den;
  logic [32:0]         d33;
  logic [15:0]         dh;
  logic [32:0]         mag;
  logic [32:0]         mag_r;
  logic                neg_r;
  logic [phib_pkg::PROD_W-1:0] prod;
  logic                div_start;
  logic                div_done;
  logic [phib_pkg::PROD_W-1:0] quo;
  logic [31:0]         q32;
  logic [15:0]         q16;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, i};
    if (s >= (CW + 1)'(DEPTH)) s = s - (CW + 1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic phib_pkg::out_item_t status_only(input logic [3:0] st);
    phib_pkg::out_item_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  phib_div #(.NW(phib_pkg::PROD_W), .DW(phib_pkg::DEN_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign full       = (count == CW'(DEPTH));
  assign oldest_inc = (oldest == AW'(DEPTH - 1)) ? '0 : oldest + AW'(1);
  assign mid        = lo + ((hi - lo) >> 1);
  assign idx_prev   = (idx == '0) ? '0 : idx - CW'(1);
  assign q32        = neg_r ? -quo[31:0] : quo[31:0];
  assign q16        = q32[15:0];

  always_comb begin
    pick = (lo >= count) ? count - CW'(1) : lo;
    if (in_r.opcode == phib_pkg::OP_YAW && pick == '0) pick = CW'(1);
  end

  always_comb begin
    raddr = oldest;
    case (state)
      S_APP_RD: raddr = slot(oldest, count - CW'(1));
      S_LK_RD1: raddr = slot(oldest, count - CW'(1));
      S_BS_RD:  raddr = slot(oldest, mid);
      S_RD_B:   raddr = slot(oldest, idx);
      S_RD_A:   raddr = slot(oldest, idx_prev);
      default:  raddr = oldest;
    endcase
  end

  always_comb begin
    wdata = '{time_ms: in_r.time_ms, pos_x: in_r.pos_x, pos_y: in_r.pos_y,
              heading: in_r.heading};
    we    = 1'b0;
    waddr = full ? oldest : slot(oldest, count);
    if (state == S_APP_CHK && rdata.time_ms == in_r.time_ms) begin
      we    = 1'b1;
      waddr = slot(oldest, count - CW'(1));
    end else if (state == S_APP_WR) begin
      we = 1'b1;
    end
  end

  always_comb begin
    dh = eb.heading - ea.heading;
    if (phase == PH_X) begin
      d33 = {eb.pos_x[31], eb.pos_x} - {ea.pos_x[31], ea.pos_x};
    end else if (phase == PH_Y) begin
      d33 = {eb.pos_y[31], eb.pos_y} - {ea.pos_y[31], ea.pos_y};
    end else begin
      d33 = {{17{dh[15]}}, dh};
    end
    mag = d33[32] ? -d33 : d33;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_X;
      out_valid  <= 1'b0;
      oldest     <= '0;
      count      <= '0;
      cur_epoch  <= '0;
      have_epoch <= 1'b0;
      retention  <= phib_pkg::RETENTION_RST;
      max_gap    <= phib_pkg::MAX_GAP_RST;
      div_start  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          phib_pkg::CFG_RETENTION: retention <= cfg_data;
          phib_pkg::CFG_MAX_GAP:   max_gap   <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_r <= in_item;
            if (in_item.opcode == phib_pkg::OP_NONE || !in_item.host_clock) begin
              res   <= status_only(phib_pkg::ST_UNSET);
              state <= S_DONE;
            end else if (in_item.opcode == phib_pkg::OP_APPEND) begin
              cur_epoch  <= in_item.epoch;
              have_epoch <= 1'b1;
              if (have_epoch && in_item.epoch != cur_epoch) begin
                oldest <= '0;
                count  <= '0;
                res    <= status_only(phib_pkg::ST_EPOCH);
                state  <= S_APP_WR;
              end else begin
                res   <= status_only(phib_pkg::ST_APPENDED);
                state <= (count == '0) ? S_APP_WR : S_APP_RD;
              end
            end else if (count == '0 ||
                         (in_item.opcode == phib_pkg::OP_YAW && count < CW'(2))) begin
              res   <= status_only(phib_pkg::ST_EMPTY);
              state <= S_DONE;
            end else begin
              res   <= '0;
              state <= S_LK_RD0;
            end
          end
        end
        S_APP_RD: state <= S_APP_CHK;
        S_APP_CHK: begin
          if (rdata.time_ms == in_r.time_ms) begin
            res.status <= phib_pkg::ST_REVISED;
            state      <= S_DONE;
          end else if (in_r.time_ms < rdata.time_ms) begin
            res.status <= phib_pkg::ST_OOO;
            state      <= S_DONE;
          end else begin
            state <= S_APP_WR;
          end
        end
        S_APP_WR: begin
          if (full) oldest <= oldest_inc;
          else count <= count + CW'(1);
          state <= S_EXP_RD;
        end
        S_EXP_RD: state <= (count > CW'(1)) ? S_EXP_CHK : S_DONE;
        S_EXP_CHK: begin
          if (in_r.time_ms - rdata.time_ms > retention) begin
            oldest <= oldest_inc;
            count  <= count - CW'(1);
            state  <= S_EXP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_LK_RD0: state <= S_LK_RD1;
        S_LK_RD1: begin
          ea    <= rdata;
          state <= S_LK_CHK;
        end
        S_LK_CHK: begin
          res.cur_epoch <= cur_epoch;
          if (in_r.time_ms < ea.time_ms) begin
            res.status <= phib_pkg::ST_EXPIRED;
            state      <= S_DONE;
          end else if (in_r.time_ms > rdata.time_ms) begin
            res.status <= phib_pkg::ST_PENDING;
            state      <= S_DONE;
          end else begin
            lo    <= '0;
            hi    <= count;
            state <= S_BS_RD;
          end
        end
        S_BS_RD: state <= (lo < hi) ? S_BS_CHK : S_PICK;
        S_BS_CHK: begin
          if (rdata.time_ms < in_r.time_ms) lo <= mid + CW'(1);
          else hi <= mid;
          state <= S_BS_RD;
        end
        S_PICK: begin
          idx   <= pick;
          state <= S_RD_B;
        end
        S_RD_B: state <= S_RD_A;
        S_RD_A: begin
          eb    <= rdata;
          state <= S_EVAL;
        end
        S_EVAL: begin
          ea <= rdata;
          if (in_r.opcode == phib_pkg::OP_POSE &&
              (eb.time_ms == in_r.time_ms || idx == '0)) begin
            res.status      <= phib_pkg::ST_OK;
            res.out_x       <= eb.pos_x;
            res.out_y       <= eb.pos_y;
            res.out_heading <= eb.heading;
            res.exact       <= 1'b1;
            state           <= S_DONE;
          end else if ((in_r.opcode == phib_pkg::OP_YAW && eb.time_ms <= rdata.time_ms) ||
                       (eb.time_ms - rdata.time_ms > max_gap)) begin
            res.status <= phib_pkg::ST_GAP;
            state      <= S_DONE;
          end else begin
            den   <= eb.time_ms - rdata.time_ms;
            num   <= (in_r.opcode == phib_pkg::OP_POSE) ? in_r.time_ms - rdata.time_ms
                                                        : phib_pkg::MS_PER_S;
            phase <= (in_r.opcode == phib_pkg::OP_POSE) ? PH_X : PH_YAW;
            state <= S_LSET;
          end
        end
        S_LSET: begin
          mag_r <= mag;
          neg_r <= d33[32];
          state <= S_MUL;
        end
        S_MUL: begin
          prod      <= {32'b0, mag_r} * {33'b0, num};
          div_start <= 1'b1;
          state     <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (phase)
              PH_X: begin
                res.out_x <= ea.pos_x + q32;
                phase     <= PH_Y;
                state     <= S_LSET;
              end
              PH_Y: begin
                res.out_y <= ea.pos_y + q32;
                phase     <= PH_H;
                state     <= S_LSET;
              end
              PH_H: begin
                res.out_heading <= ea.heading + q16;
                res.status      <= phib_pkg::ST_OK;
                state           <= S_DONE;
              end
              default: begin
                res.yaw_rate <= q32;
                res.status   <= phib_pkg::ST_OK;
                state        <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_item  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/phib_chk.sv]
// Port-level checks of the pose history buffer, bound to its top level.
// Depends on phib_pkg and pose_history_interp_buffer.
`timescale 1ns / 1ps
`default_nettype none
module phib_chk (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire phib_pkg::out_item_t            out_item
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item valid after reset");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != phib_pkg::ST_OK |->
      out_item.out_x == 0 && out_item.out_y == 0 && out_item.out_heading == 0 &&
      out_item.yaw_rate == 0 && out_item.exact == 1'b0)
    else $error("payload set on a result that is not ok");

  a_epoch: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == phib_pkg::ST_UNSET ||
                  out_item.status == phib_pkg::ST_EMPTY ||
                  out_item.status == phib_pkg::ST_APPENDED) |-> out_item.cur_epoch == 0)
    else $error("epoch reported on a result that does not reach the store");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input item taken while the previous one is in progress");

endmodule

bind pose_history_interp_buffer phib_chk u_phib_chk (.*);
`default_nettype wire
